FILE: hdl/bbs_pkg.sv
// Shared types, constants and helpers for the 3x3 box blur stream block.
`timescale 1ns / 1ps
`default_nettype none
package bbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 65535;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 16;
	localparam int LS_DEPTH   = 2 * MAX_WIDTH;
	localparam int LS_AW      = $clog2(LS_DEPTH);
	localparam int PIX_W      = 24;
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_MUL,
		ST_OUT
	} bbs_state_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       sum;
		logic       mul;
		logic [1:0] sel;
		logic       last;
	} bbs_cmd_t;

	typedef struct packed {
		logic [3:0] mask;
	} bbs_stat_t;

	// ceil(2^16 / cnt) for the neighborhood sizes that occur
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd6:    r = 17'd10923;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// lowest set bit of mask at or above position from; bit 2 flags a hit
	function automatic logic [2:0] next_sel(input logic [3:0] mask, input logic [2:0] from);
		logic [2:0] r;
		r = 3'b000;
		for (int n = 3; n >= 0; n--) begin
			if (mask[n] && (3'(n) >= from)) begin
				r = {1'b1, 2'(n)};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/bbs_ctrl.sv
// Controller state machine sequencing load, sum, divide and output steps.
`timescale 1ns / 1ps
`default_nettype none
module bbs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire bbs_pkg::bbs_stat_t stat,
	output bbs_pkg::bbs_cmd_t      cmd
);
	import bbs_pkg::*;

	bbs_state_t state_q, state_nx;
	logic [1:0] sel_q, sel_nx;
	logic [2:0] first_hit, after_hit;

	assign first_hit = next_sel(stat.mask, 3'd0);
	assign after_hit = next_sel(stat.mask, {1'b0, sel_q} + 3'd1);

	always_comb begin
		state_nx = state_q;
		sel_nx   = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				state_nx = first_hit[2] ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) begin
					if (after_hit[2]) begin
						state_nx = ST_SUM;
						sel_nx   = after_hit[1:0];
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
		if (state_q == ST_LOAD) begin
			sel_nx = first_hit[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 2'd0;
		end else begin
			sel_q   <= sel_nx;
			state_q <= state_nx;
		end
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		m_tvalid    = (state_q == ST_OUT);
		cmd.capture = (state_q == ST_IDLE) && s_tvalid;
		cmd.load    = (state_q == ST_LOAD);
		cmd.sum     = (state_q == ST_SUM);
		cmd.mul     = (state_q == ST_MUL);
		cmd.sel     = sel_q;
		cmd.last    = !after_hit[2];
	end

endmodule
`default_nettype wire

FILE: hdl/bbs_datapath.sv
// Datapath: config registers, line store, window, counters, sums and divider.
`timescale 1ns / 1ps
`default_nettype none
module bbs_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic [23:0]          s_tdata,
	output logic [55:0]               m_tdata,
	output logic                      m_tlast,
	input  wire bbs_pkg::bbs_cmd_t    cmd,
	output bbs_pkg::bbs_stat_t        stat
);
	import bbs_pkg::*;

	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] px_q;
	logic [PIX_W-1:0] rd_lo_q, rd_hi_q;
	logic [LS_AW-1:0] wr_addr_q;
	logic [PIX_W-1:0] mem_q [LS_DEPTH];
	logic [PIX_W-1:0] win_q [9];
	logic             i_ge1_q, i_ge2_q, j_ge1_q, j_ge2_q;
	logic [3:0]       mask_q;
	logic [3:0]       mask_nx;
	logic [ROW_W-1:0] i_q;
	logic [COL_W-1:0] j_q;
	logic [SUM_W-1:0] sr_s1, sg_s1, sb_s1;
	logic [3:0]       cnt_s1;
	logic [ROW_W-1:0] orow_s1;
	logic [COL_W-1:0] ocol_s1;
	logic [7:0]       red_q, green_q, blue_q;
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;
	logic             last_q;
	logic             cfg_wr;
	logic [10:0]      wdat;

	assign cfg_wr = cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
	assign wdat   = cfg_data[10:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= COL_W'(639);
			hlast_q <= ROW_W'(479);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (wdat == 11'd0) wlast_q <= '0;
					else if (wdat > 11'(MAX_WIDTH)) wlast_q <= COL_W'(MAX_WIDTH - 1);
					else wlast_q <= COL_W'(wdat - 11'd1);
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data == 16'd0) hlast_q <= '0;
					else hlast_q <= cfg_data - 16'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q      <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
			wr_addr_q <= {row_q[0], col_q};
			rd_lo_q   <= mem_q[{row_q[0], col_q}];
			rd_hi_q   <= mem_q[{~row_q[0], col_q}];
		end
		if (cmd.load) begin
			mem_q[wr_addr_q] <= px_q;
		end
	end

	always_comb begin
		mask_nx[0] = (row_q != '0) && (col_q != '0);
		mask_nx[1] = (row_q != '0) && (col_q == wlast_q);
		mask_nx[2] = (row_q == hlast_q) && (col_q != '0);
		mask_nx[3] = (row_q == hlast_q) && (col_q == wlast_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int n = 0; n < 9; n++) win_q[n] <= '0;
			mask_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
			for (int n = 0; n < 9; n++) win_q[n] <= '0;
		end else if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= rd_lo_q;
			win_q[5] <= rd_hi_q;
			win_q[8] <= px_q;
			mask_q   <= mask_nx;
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			i_q     <= row_q;
			j_q     <= col_q;
			i_ge1_q <= (row_q != '0);
			i_ge2_q <= (row_q > ROW_W'(1));
			j_ge1_q <= (col_q != '0);
			j_ge2_q <= (col_q > COL_W'(1));
		end
	end

	assign stat.mask = cmd.load ? mask_nx : mask_q;

	logic [2:0]       rowm, colm;
	logic [1:0]       rcnt, ccnt;
	logic [SUM_W-1:0] sr, sg, sb;

	always_comb begin
		rowm[0] = !cmd.sel[1] && i_ge2_q;
		rowm[1] = i_ge1_q;
		rowm[2] = 1'b1;
		colm[0] = !cmd.sel[0] && j_ge2_q;
		colm[1] = j_ge1_q;
		colm[2] = 1'b1;
		rcnt = 2'(rowm[0]) + 2'(rowm[1]) + 2'(rowm[2]);
		ccnt = 2'(colm[0]) + 2'(colm[1]) + 2'(colm[2]);
		sr = '0;
		sg = '0;
		sb = '0;
		for (int k = 0; k < 3; k++) begin
			for (int m = 0; m < 3; m++) begin
				if (rowm[k] && colm[m]) begin
					sr = sr + SUM_W'(win_q[k*3+m][23:16]);
					sg = sg + SUM_W'(win_q[k*3+m][15:8]);
					sb = sb + SUM_W'(win_q[k*3+m][7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sr_s1   <= sr;
			sg_s1   <= sg;
			sb_s1   <= sb;
			cnt_s1  <= 4'(rcnt) * 4'(ccnt);
			orow_s1 <= cmd.sel[1] ? i_q : i_q - ROW_W'(1);
			ocol_s1 <= cmd.sel[0] ? j_q : j_q - COL_W'(1);
		end
	end

	logic [RECIP_W-1:0]         rc;
	logic [SUM_W+RECIP_W-1:0]   pr, pg, pb;

	assign rc = recip(cnt_s1);
	assign pr = (SUM_W+RECIP_W)'(sr_s1 + SUM_W'(cnt_s1[3:1])) * (SUM_W+RECIP_W)'(rc);
	assign pg = (SUM_W+RECIP_W)'(sg_s1 + SUM_W'(cnt_s1[3:1])) * (SUM_W+RECIP_W)'(rc);
	assign pb = (SUM_W+RECIP_W)'(sb_s1 + SUM_W'(cnt_s1[3:1])) * (SUM_W+RECIP_W)'(rc);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			red_q   <= pr[RECIP_SH +: 8];
			green_q <= pg[RECIP_SH +: 8];
			blue_q  <= pb[RECIP_SH +: 8];
			orow_q  <= orow_s1;
			ocol_q  <= ocol_s1;
			last_q  <= cmd.last;
		end
	end

	assign m_tdata = {6'd0, ocol_q, orow_q, blue_q, green_q, red_q};
	assign m_tlast = last_q;

endmodule
`default_nettype wire

FILE: hdl/box_blur_3x3_stream_top.sv
// Top level of the streaming 3x3 box blur.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: red, green, blue
// m_       out  m_tvalid/m_tready    m_tdata: red, green, blue, row, column; m_tlast
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request runs the load step, then sum, divide and output for each of its 0 to 4
// results; output stalls hold the output step, and no new pixel is taken meanwhile.
// Reset clears counters and window and loads 640 x 480; the line store is not cleared.
// Config writes are always taken; width and height writes restart the frame.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_stream_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // red_out, green_out, blue_out, out_row, out_column
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import bbs_pkg::*;

	bbs_cmd_t  cmd;
	bbs_stat_t stat;

	assign cfg_ready = 1'b1;

	bbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for the streaming 3x3 box blur: directed table plus random frames.
`timescale 1ns / 1ps
module testbench;
	import bbs_pkg::*;

	typedef struct {
		logic [7:0]  red, green, blue;
		logic [15:0] row;
		logic [9:0]  column;
		logic        last;
	} blur_pix_t;

	typedef struct {
		logic [23:0] rgb;
		logic        known;
		logic [7:0]  red, green, blue;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	box_blur_3x3_stream_top DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [23:0] line_mem [0:2*MAX_WIDTH-1];
	logic [23:0] win [0:8];
	int unsigned cur_row, cur_col, width_reg, height_reg;
	blur_pix_t blur_q [$];
	logic [7:0] known_red [$], known_green [$], known_blue [$];
	bit known_flag [$];
	int errors = 0;
	bit calm = 1'b0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic int unsigned eff(input int unsigned v, input int unsigned mx);
		if (v == 0) return 1;
		return v > mx ? mx : v;
	endfunction

	function automatic void clear_frame();
		cur_row = 0;
		cur_col = 0;
		for (int k = 0; k < 9; k++) win[k] = '0;
	endfunction

	function automatic void predict_pixel(input logic [23:0] px, input bit known);
		int unsigned w, h, lo, hi, n;
		int i, j, nr, nc;
		int rows [2], cols [2];
		blur_pix_t p;
		w = eff(width_reg, MAX_WIDTH);
		h = eff(height_reg, MAX_HEIGHT);
		if (cur_col >= w || cur_row >= h) clear_frame();
		i = cur_row;
		j = cur_col;
		lo = (cur_row & 1) * MAX_WIDTH + cur_col;
		hi = ((cur_row + 1) & 1) * MAX_WIDTH + cur_col;
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = line_mem[lo];
		win[5] = line_mem[hi];
		win[8] = px;
		line_mem[lo] = px;
		nr = 0;
		nc = 0;
		if (i >= 1) rows[nr++] = i - 1;
		if (cur_row == h - 1) rows[nr++] = i;
		if (j >= 1) cols[nc++] = j - 1;
		if (cur_col == w - 1) cols[nc++] = j;
		n = 0;
		for (int a = 0; a < nr; a++)
			for (int b = 0; b < nc; b++) begin
				int unsigned sr, sg, sb, cnt;
				sr = 0; sg = 0; sb = 0; cnt = 0;
				for (int k = 0; k < 3; k++)
					for (int m = 0; m < 3; m++) begin
						int rr, cc;
						rr = i - 2 + k;
						cc = j - 2 + m;
						if (rr < 0 || cc < 0) continue;
						if (rr < rows[a]-1 || rr > rows[a]+1 || cc < cols[b]-1 || cc > cols[b]+1)
							continue;
						sr += win[k*3+m][7:0];
						sg += win[k*3+m][15:8];
						sb += win[k*3+m][23:16];
						cnt++;
					end
				if (cnt == 0) cnt = 1;
				p.red = 8'((sr + cnt/2) / cnt);
				p.green = 8'((sg + cnt/2) / cnt);
				p.blue = 8'((sb + cnt/2) / cnt);
				p.row = 16'(rows[a]);
				p.column = 10'(cols[b]);
				p.last = (a == nr-1) && (b == nc-1);
				blur_q.push_back(p);
				n++;
			end
		// a typed-in value applies to the single result of a one-pixel frame
		if (known && n == 1) begin
			blur_q[$].red = known_red[0];
			blur_q[$].green = known_green[0];
			blur_q[$].blue = known_blue[0];
		end
		cur_col++;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= h) cur_row = 0;
		end
	endfunction

	task automatic idle_src();
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [23:0] px, input bit known);
		idle_src();
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_pixel(px, known);
		if (known) begin
			void'(known_red.pop_front());
			void'(known_green.pop_front());
			void'(known_blue.pop_front());
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (blur_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
		else height_reg = val;
		clear_frame();
	endtask

	task automatic send_frame(input int unsigned pixels, input int unsigned bias);
		for (int n = 0; n < pixels; n++) begin
			logic [23:0] px;
			case (bias)
				0: px = 24'($urandom);
				1: px = {24{$urandom_range(0, 1) == 1}};
				default: px = ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0) ^ (24'($urandom) & 24'h030303);
			endcase
			send_pixel(px, 1'b0);
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			blur_pix_t e;
			if (blur_q.size() == 0) begin
				$display("mismatch: result with nothing expected");
				errors++;
			end else begin
				e = blur_q.pop_front();
				if (m_tdata[7:0] !== e.red) report("red", int'(m_tdata[7:0]), int'(e.red));
				if (m_tdata[15:8] !== e.green)
					report("green", int'(m_tdata[15:8]), int'(e.green));
				if (m_tdata[23:16] !== e.blue)
					report("blue", int'(m_tdata[23:16]), int'(e.blue));
				if (m_tdata[39:24] !== e.row) report("row", int'(m_tdata[39:24]), int'(e.row));
				if (m_tdata[49:40] !== e.column)
					report("column", int'(m_tdata[49:40]), int'(e.column));
				if (m_tdata[55:50] !== 6'd0) report("pad", int'(m_tdata[55:50]), 0);
				if (m_tlast !== e.last) report("last", int'(m_tlast), int'(e.last));
			end
		end
	end

	initial begin
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!calm) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	stim_row_t table_rows [6] = '{
		'{24'h000000, 1'b1, 8'h00, 8'h00, 8'h00},
		'{24'hFFFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
		'{24'hFF0000, 1'b1, 8'h00, 8'h00, 8'hFF},
		'{24'h00FF00, 1'b1, 8'h00, 8'hFF, 8'h00},
		'{24'h0000FF, 1'b1, 8'hFF, 8'h00, 8'h00},
		'{24'hA55A3C, 1'b1, 8'h3C, 8'h5A, 8'hA5}
	};

	initial begin
		for (int k = 0; k < 2*MAX_WIDTH; k++) line_mem[k] = '0;
		width_reg = 640;
		height_reg = 480;
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// one-pixel frame: the output equals the input
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		foreach (table_rows[k]) begin
			known_red.push_back(table_rows[k].red);
			known_green.push_back(table_rows[k].green);
			known_blue.push_back(table_rows[k].blue);
			send_pixel(table_rows[k].rgb, table_rows[k].known);
		end
		// zero sizes clamp to one; 3x3 and thin frames via predictor
		write_reg(REG_FRAME_WIDTH, 16'd0);
		write_reg(REG_FRAME_HEIGHT, 16'd0);
		send_frame(2, 1);
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		send_frame(9, 2);
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'd4);
		send_frame(4, 0);
		drain();
		// random frames, all of small sizes
		for (int f = 0; f < 14; f++) begin
			int unsigned w, h, pix;
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			write_reg(REG_FRAME_WIDTH, 16'(w));
			write_reg(REG_FRAME_HEIGHT, 16'(h));
			pix = w * h * $urandom_range(1, 2);
			if (f == 6) pix = pix / 2 + 1;
			if (f >= 11) calm = 1'b1;
			send_frame(pix, $urandom_range(0, 2));
		end
		calm = 1'b0;
		// high width saturates; frame abandoned by a register write
		write_reg(REG_FRAME_WIDTH, 16'h07FF);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		send_frame(40, 0);
		write_reg(REG_FRAME_WIDTH, 16'd2);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		calm = 1'b1;
		send_frame(12, 0);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (blur_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) $display("testbench OK");
		else $display("testbench NOT OK");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/bbs_pkg.sv
hdl/bbs_ctrl.sv
hdl/bbs_datapath.sv
hdl/box_blur_3x3_stream_top.sv
tb/sv/testbench.sv
